@@ hdl/fwil_pkg.sv @@
// ----------------------------------------------------------------------------
// fwil_pkg: shared types and constants for the full-width indent lexer
// Word types, lexer modes, controller states, datapath command and status, token kinds,
// code points and character classes.
`default_nettype none
package fwil_pkg;

  typedef struct packed {
    logic        kind;
    logic [20:0] code_point;
  } in_word_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] line;
    logic [31:0] content_start;
    logic [15:0] content_length;
    logic [62:0] number_value;
    logic        number_overflow;
    logic        lexer_error;
    logic        last;
  } out_word_t;

  typedef enum logic [2:0] {
    M_IDLE, M_CMP, M_NUM, M_SYM, M_STR, M_CMT, M_SPC, M_NLW
  } lex_mode_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EMIT_A, S_EMIT_B
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic emit_a;
    logic emit_b;
  } dp_cmd_t;

  typedef struct packed {
    logic new_a;
    logic new_b;
    logic a_last;
    logic b_pend;
  } dp_status_t;

  localparam logic [5:0] K_LPAREN = 6'd0;
  localparam logic [5:0] K_RPAREN = 6'd1;
  localparam logic [5:0] K_LBRACE = 6'd2;
  localparam logic [5:0] K_RBRACE = 6'd3;
  localparam logic [5:0] K_COMMA  = 6'd4;
  localparam logic [5:0] K_ASSIGN = 6'd5;
  localparam logic [5:0] K_DOT    = 6'd6;
  localparam logic [5:0] K_MINUS  = 6'd7;
  localparam logic [5:0] K_STAR   = 6'd8;
  localparam logic [5:0] K_COLON  = 6'd9;
  localparam logic [5:0] K_PLUS   = 6'd10;
  localparam logic [5:0] K_SLASH  = 6'd11;
  localparam logic [5:0] K_GT     = 6'd12;
  localparam logic [5:0] K_LT     = 6'd13;
  localparam logic [5:0] K_NAMI   = 6'd14;
  localparam logic [5:0] K_EQ     = 6'd15;
  localparam logic [5:0] K_GEQ    = 6'd16;
  localparam logic [5:0] K_LEQ    = 6'd17;
  localparam logic [5:0] K_NEQ    = 6'd18;
  localparam logic [5:0] K_NEWL   = 6'd19;
  localparam logic [5:0] K_INDENT = 6'd20;
  localparam logic [5:0] K_DEDENT = 6'd21;
  localparam logic [5:0] K_NUMBER = 6'd22;
  localparam logic [5:0] K_STRING = 6'd23;
  localparam logic [5:0] K_SYMBOL = 6'd24;
  localparam logic [5:0] K_FUNC   = 6'd25;
  localparam logic [5:0] K_RETURN = 6'd26;
  localparam logic [5:0] K_IF     = 6'd27;
  localparam logic [5:0] K_ELIF   = 6'd28;
  localparam logic [5:0] K_ELSE   = 6'd29;
  localparam logic [5:0] K_IMPORT = 6'd30;
  localparam logic [5:0] K_ASSERT = 6'd31;
  localparam logic [5:0] K_EXTERN = 6'd32;
  localparam logic [5:0] K_END    = 6'd33;

  localparam logic [20:0] C_NUL   = 21'h000000;
  localparam logic [20:0] C_NL    = 21'h00000A;
  localparam logic [20:0] C_SPACE = 21'h003000;
  localparam logic [20:0] C_COMMA = 21'h003001;
  localparam logic [20:0] C_LSQ   = 21'h00300C;
  localparam logic [20:0] C_RSQ   = 21'h00300D;
  localparam logic [20:0] C_LBR   = 21'h003010;
  localparam logic [20:0] C_RBR   = 21'h003011;
  localparam logic [20:0] C_NAMI  = 21'h00301C;
  localparam logic [20:0] C_DOT   = 21'h0030FB;
  localparam logic [20:0] C_NOT   = 21'h00FF01;
  localparam logic [20:0] C_SHARP = 21'h00FF03;
  localparam logic [20:0] C_LPAR  = 21'h00FF08;
  localparam logic [20:0] C_RPAR  = 21'h00FF09;
  localparam logic [20:0] C_STAR  = 21'h00FF0A;
  localparam logic [20:0] C_PLUS  = 21'h00FF0B;
  localparam logic [20:0] C_MINUS = 21'h00FF0D;
  localparam logic [20:0] C_SLASH = 21'h00FF0F;
  localparam logic [20:0] C_D0    = 21'h00FF10;
  localparam logic [20:0] C_D9    = 21'h00FF19;
  localparam logic [20:0] C_COLON = 21'h00FF1A;
  localparam logic [20:0] C_LT    = 21'h00FF1C;
  localparam logic [20:0] C_EQ    = 21'h00FF1D;
  localparam logic [20:0] C_GT    = 21'h00FF1E;

  localparam logic [62:0] NUM_LIMIT = {63{1'b1}};
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  function automatic logic is_cmp(input logic [20:0] c);
    return (c == C_EQ) || (c == C_GT) || (c == C_LT) || (c == C_NOT);
  endfunction

  function automatic logic is_digit(input logic [20:0] c);
    return (c >= C_D0) && (c <= C_D9);
  endfunction

  function automatic logic is_punct(input logic [20:0] c);
    logic r;
    case (c) inside
      C_LPAR, C_RPAR, C_LBR, C_RBR, C_COMMA, C_EQ, C_DOT, C_MINUS, C_STAR,
      C_COLON, C_PLUS, C_SLASH, C_GT, C_LT, C_NAMI: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_symbolic(input logic [20:0] c);
    logic r;
    case (c) inside
      C_LPAR, C_RPAR, C_COMMA, C_SPACE, C_NL, C_EQ, C_DOT, C_STAR, C_COLON,
      C_SHARP, C_MINUS, C_PLUS, C_NUL, C_SLASH, C_GT, C_NOT, C_LT, C_LBR,
      C_RBR, C_NAMI: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] punct_kind(input logic [20:0] c);
    logic [5:0] k;
    unique case (c)
      C_LPAR:  k = K_LPAREN;
      C_RPAR:  k = K_RPAREN;
      C_LBR:   k = K_LBRACE;
      C_RBR:   k = K_RBRACE;
      C_COMMA: k = K_COMMA;
      C_EQ:    k = K_ASSIGN;
      C_DOT:   k = K_DOT;
      C_MINUS: k = K_MINUS;
      C_STAR:  k = K_STAR;
      C_COLON: k = K_COLON;
      C_PLUS:  k = K_PLUS;
      C_SLASH: k = K_SLASH;
      C_GT:    k = K_GT;
      C_LT:    k = K_LT;
      C_NAMI:  k = K_NAMI;
      default: k = K_SYMBOL;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] kw_kind(input logic [15:0] len, input logic [20:0] b0,
                                         input logic [20:0] b1, input logic [20:0] b2,
                                         input logic [20:0] b3);
    logic [5:0] k;
    k = K_SYMBOL;
    if (len == 16'd2) begin
      if (b0 == 21'h0095A2 && b1 == 21'h006570) k = K_FUNC;
      else if (b0 == 21'h008FD4 && b1 == 21'h003059) k = K_RETURN;
      else if (b0 == 21'h003082 && b1 == 21'h003057) k = K_IF;
      else if (b0 == 21'h005C0E && b1 == 21'h005165) k = K_IMPORT;
      else if (b0 == 21'h0078BA && b1 == 21'h008A8D) k = K_ASSERT;
      else if (b0 == 21'h005916 && b1 == 21'h005074) k = K_EXTERN;
    end else if (len == 16'd3) begin
      if (b0 == 21'h00305D && b1 == 21'h00306E && b2 == 21'h004ED6) k = K_ELSE;
    end else if (len == 16'd4) begin
      if (b0 == 21'h004ED6 && b1 == 21'h003067 && b2 == 21'h003082 && b3 == 21'h003057)
        k = K_ELIF;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

@@ hdl/fwil_ctrl.sv @@
// ----------------------------------------------------------------------------
// fwil_ctrl: lexer sequencer
// Accepts words, then steps the datapath through its pending token run and
// its trailing token, and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
module fwil_ctrl
  import fwil_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.new_a) state_nxt = S_EMIT_A;
          else if (status.new_b) state_nxt = S_EMIT_B;
        end
      end
      S_EMIT_A: begin
        if (out_free) begin
          cmd.emit_a = 1'b1;
          if (status.a_last) state_nxt = status.b_pend ? S_EMIT_B : S_IDLE;
        end
      end
      S_EMIT_B: begin
        if (out_free) begin
          cmd.emit_b = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.emit_a || cmd.emit_b) out_valid_nxt = 1'b1;
    else if (out_free) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

@@ hdl/fwil_dp.sv @@
// ----------------------------------------------------------------------------
// fwil_dp: lexer datapath
// Holds lexer state, decodes each accepted word into a token run and a
// trailing token, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module fwil_dp
  import fwil_pkg::*;
#(
  parameter int MAX_INDENT = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_word_t in_word,
  input  wire dp_cmd_t  cmd,
  output dp_status_t    status,
  output out_word_t     out_word
);

  localparam int CW = $clog2(MAX_INDENT + 1);
  localparam logic [CW-1:0] IND_MAX = CW'(MAX_INDENT);

  lex_mode_t     mode_r, mode_nxt;
  logic [20:0]   held_r, held_nxt;
  logic [CW-1:0] ind_r, ind_nxt;
  logic [CW-1:0] spc_r, spc_nxt;
  logic [31:0]   line_r, line_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [31:0]   tstart_r, tstart_nxt;
  logic [15:0]   tlen_r, tlen_nxt;
  logic [62:0]   acc_r, acc_nxt;
  logic          ovf_r, ovf_nxt;
  logic          err_r, err_nxt;
  logic [20:0]   kw_r [4];
  logic [3:0]    kw_we;
  logic [20:0]   kw_d [4];

  logic [CW-1:0] a_cnt_r, a_cnt;
  logic [5:0]    a_kind_r, a_kind;
  logic [31:0]   a_line_r, a_line;
  logic [31:0]   a_start_r, a_start;
  logic [15:0]   a_len_r, a_len;
  logic [62:0]   a_val_r, a_val;
  logic          a_ovf_r, a_ovf;
  logic          b_vld_r, b_vld;
  logic [5:0]    b_kind_r, b_kind;
  logic [31:0]   b_line_r;
  logic [31:0]   b_start_r, b_start;
  logic [15:0]   b_len_r, b_len;
  logic          efirst_r, efirst;
  out_word_t     out_r;

  logic [20:0]   c;
  logic [66:0]   num_sum;
  logic          set_err, do_start, any_tok, err_eff;
  logic [15:0]   tlen_inc;

  always_comb begin
    c        = in_word.code_point;
    tlen_inc = (tlen_r != LEN_MAX) ? tlen_r + 16'd1 : tlen_r;
    num_sum  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {63'd0, 4'(c - C_D0)};

    mode_nxt   = mode_r;
    held_nxt   = held_r;
    ind_nxt    = ind_r;
    spc_nxt    = spc_r;
    line_nxt   = line_r;
    pos_nxt    = pos_r;
    tstart_nxt = tstart_r;
    tlen_nxt   = tlen_r;
    acc_nxt    = acc_r;
    ovf_nxt    = ovf_r;
    kw_we      = '0;
    for (int i = 0; i < 4; i++) kw_d[i] = c;

    a_cnt   = '0;
    a_kind  = K_SYMBOL;
    a_line  = line_r;
    a_start = tstart_r;
    a_len   = tlen_r;
    a_val   = '0;
    a_ovf   = 1'b0;
    b_vld   = 1'b0;
    b_kind  = K_END;
    b_start = '0;
    b_len   = '0;
    set_err = 1'b0;
    do_start = 1'b0;

    if (in_word.kind) begin
      unique case (mode_r)
        M_CMP: begin
          a_cnt  = CW'(1);
          a_len  = 16'd1;
          a_kind = (held_r == C_NOT) ? K_SYMBOL : punct_kind(held_r);
        end
        M_NUM: begin
          a_cnt  = CW'(1);
          a_kind = K_NUMBER;
          a_val  = acc_r;
          a_ovf  = ovf_r;
        end
        M_SYM: begin
          a_cnt  = CW'(1);
          a_kind = kw_kind(tlen_r, kw_r[0], kw_r[1], kw_r[2], kw_r[3]);
        end
        M_SPC: begin
          a_kind  = (spc_r > ind_r) ? K_INDENT : K_DEDENT;
          a_cnt   = (spc_r > ind_r) ? spc_r - ind_r : ind_r - spc_r;
          a_start = '0;
          a_len   = '0;
          ind_nxt = spc_r;
        end
        M_NLW: begin
          a_kind  = K_DEDENT;
          a_cnt   = ind_r;
          a_start = '0;
          a_len   = '0;
          ind_nxt = '0;
        end
        default: ;
      endcase
      b_vld    = 1'b1;
      mode_nxt = M_IDLE;
    end else begin
      pos_nxt = pos_r + 32'd1;
      unique case (mode_r)
        M_IDLE: do_start = 1'b1;
        M_CMP: begin
          if (is_cmp(c)) begin
            if (c == C_EQ) begin
              a_cnt  = CW'(1);
              a_len  = 16'd2;
              unique case (held_r)
                C_EQ:    a_kind = K_EQ;
                C_GT:    a_kind = K_GEQ;
                C_LT:    a_kind = K_LEQ;
                default: a_kind = K_NEQ;
              endcase
              mode_nxt = M_IDLE;
            end else begin
              set_err = 1'b1;
              if (held_r == C_NOT) begin
                mode_nxt = M_SYM;
                tlen_nxt = 16'd1;
                kw_we[0] = 1'b1;
                kw_d[0]  = C_NOT;
              end else begin
                a_cnt    = CW'(1);
                a_len    = 16'd1;
                a_kind   = punct_kind(held_r);
                mode_nxt = M_IDLE;
              end
            end
          end else if (held_r == C_NOT) begin
            if (!is_symbolic(c)) begin
              mode_nxt = M_SYM;
              tlen_nxt = 16'd2;
              kw_we[0] = 1'b1;
              kw_d[0]  = C_NOT;
              kw_we[1] = 1'b1;
            end else begin
              a_cnt    = CW'(1);
              a_len    = 16'd1;
              a_kind   = K_SYMBOL;
              do_start = 1'b1;
            end
          end else begin
            a_cnt    = CW'(1);
            a_len    = 16'd1;
            a_kind   = punct_kind(held_r);
            do_start = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            tlen_nxt = tlen_inc;
            if (!ovf_r) begin
              if (num_sum[66:63] != 4'd0) begin
                acc_nxt = NUM_LIMIT;
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = num_sum[62:0];
              end
            end
          end else begin
            a_cnt    = CW'(1);
            a_kind   = K_NUMBER;
            a_val    = acc_r;
            a_ovf    = ovf_r;
            do_start = 1'b1;
          end
        end
        M_SYM: begin
          if (!is_symbolic(c)) begin
            if (tlen_r < 16'd4) kw_we[tlen_r[1:0]] = 1'b1;
            tlen_nxt = tlen_inc;
          end else begin
            a_cnt    = CW'(1);
            a_kind   = kw_kind(tlen_r, kw_r[0], kw_r[1], kw_r[2], kw_r[3]);
            do_start = 1'b1;
          end
        end
        M_STR: begin
          if (c == C_RSQ) begin
            a_cnt    = CW'(1);
            a_kind   = K_STRING;
            mode_nxt = M_IDLE;
          end else begin
            tlen_nxt = tlen_inc;
            if (c == C_NL) line_nxt = line_r + 32'd1;
          end
        end
        M_CMT: begin
          if (c == C_NL) begin
            line_nxt = line_r + 32'd1;
            a_cnt    = CW'(1);
            a_kind   = K_NEWL;
            a_start  = '0;
            a_len    = '0;
            a_line   = line_r + 32'd1;
            mode_nxt = M_IDLE;
          end
        end
        M_SPC: begin
          if (c == C_SPACE) begin
            if (spc_r < IND_MAX) spc_nxt = spc_r + CW'(1);
          end else begin
            a_kind   = (spc_r > ind_r) ? K_INDENT : K_DEDENT;
            a_cnt    = (spc_r > ind_r) ? spc_r - ind_r : ind_r - spc_r;
            a_start  = '0;
            a_len    = '0;
            ind_nxt  = spc_r;
            do_start = 1'b1;
          end
        end
        M_NLW: begin
          if (c != C_SPACE && c != C_NL) begin
            a_kind  = K_DEDENT;
            a_cnt   = ind_r;
            a_start = '0;
            a_len   = '0;
            ind_nxt = '0;
          end
          do_start = 1'b1;
        end
        default: do_start = 1'b1;
      endcase

      if (do_start) begin
        mode_nxt = M_IDLE;
        if (is_cmp(c)) begin
          mode_nxt   = M_CMP;
          held_nxt   = c;
          tstart_nxt = pos_r;
        end else if (is_punct(c)) begin
          b_vld   = 1'b1;
          b_kind  = punct_kind(c);
          b_start = pos_r;
          b_len   = 16'd1;
        end else if (c == C_SHARP) begin
          mode_nxt = M_CMT;
        end else if (c == C_NL) begin
          line_nxt = line_r + 32'd1;
          b_vld    = 1'b1;
          b_kind   = K_NEWL;
          mode_nxt = (ind_nxt != '0) ? M_NLW : M_IDLE;
        end else if (c == C_SPACE) begin
          mode_nxt = M_SPC;
          spc_nxt  = CW'(1);
        end else if (is_digit(c)) begin
          mode_nxt   = M_NUM;
          tstart_nxt = pos_r;
          tlen_nxt   = 16'd1;
          acc_nxt    = {59'd0, 4'(c - C_D0)};
          ovf_nxt    = 1'b0;
        end else if (c == C_LSQ) begin
          mode_nxt   = M_STR;
          tstart_nxt = pos_r + 32'd1;
          tlen_nxt   = '0;
        end else begin
          mode_nxt   = M_SYM;
          tstart_nxt = pos_r;
          tlen_nxt   = 16'd1;
          kw_we[0]   = 1'b1;
        end
      end
    end

    err_eff = err_r | set_err;
    any_tok = (a_cnt != '0) || b_vld;
    if (in_word.kind) begin
      efirst  = (a_cnt != '0) && err_eff;
      err_nxt = 1'b0;
    end else begin
      efirst  = err_eff && any_tok;
      err_nxt = err_eff && !any_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= M_IDLE;
      held_r   <= '0;
      ind_r    <= '0;
      spc_r    <= '0;
      line_r   <= 32'd1;
      pos_r    <= '0;
      tstart_r <= '0;
      tlen_r   <= '0;
      acc_r    <= '0;
      ovf_r    <= 1'b0;
      err_r    <= 1'b0;
      a_cnt_r  <= '0;
      b_vld_r  <= 1'b0;
      efirst_r <= 1'b0;
    end else if (cmd.load) begin
      mode_r   <= mode_nxt;
      held_r   <= held_nxt;
      ind_r    <= ind_nxt;
      spc_r    <= spc_nxt;
      line_r   <= line_nxt;
      pos_r    <= pos_nxt;
      tstart_r <= tstart_nxt;
      tlen_r   <= tlen_nxt;
      acc_r    <= acc_nxt;
      ovf_r    <= ovf_nxt;
      err_r    <= err_nxt;
      a_cnt_r  <= a_cnt;
      b_vld_r  <= b_vld;
      efirst_r <= efirst;
    end else if (cmd.emit_a) begin
      a_cnt_r  <= a_cnt_r - CW'(1);
      efirst_r <= 1'b0;
    end else if (cmd.emit_b) begin
      b_vld_r  <= 1'b0;
      efirst_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 4; i++) begin
        if (kw_we[i]) kw_r[i] <= kw_d[i];
      end
      a_kind_r  <= a_kind;
      a_line_r  <= a_line;
      a_start_r <= a_start;
      a_len_r   <= a_len;
      a_val_r   <= a_val;
      a_ovf_r   <= a_ovf;
      b_kind_r  <= b_kind;
      b_line_r  <= line_nxt;
      b_start_r <= b_start;
      b_len_r   <= b_len;
    end
    if (cmd.emit_a) begin
      out_r.token_kind      <= a_kind_r;
      out_r.line            <= a_line_r;
      out_r.content_start   <= a_start_r;
      out_r.content_length  <= a_len_r;
      out_r.number_value    <= a_val_r;
      out_r.number_overflow <= a_ovf_r;
      out_r.lexer_error     <= efirst_r;
      out_r.last            <= (a_cnt_r == CW'(1)) && !b_vld_r;
    end else if (cmd.emit_b) begin
      out_r.token_kind      <= b_kind_r;
      out_r.line            <= b_line_r;
      out_r.content_start   <= b_start_r;
      out_r.content_length  <= b_len_r;
      out_r.number_value    <= '0;
      out_r.number_overflow <= 1'b0;
      out_r.lexer_error     <= efirst_r;
      out_r.last            <= 1'b1;
    end
  end

  assign status.new_a  = (a_cnt != '0);
  assign status.new_b  = b_vld;
  assign status.a_last = (a_cnt_r == CW'(1));
  assign status.b_pend = b_vld_r;
  assign out_word      = out_r;

endmodule
`default_nettype wire

@@ hdl/fullwidth_indent_lexer.sv @@
// ----------------------------------------------------------------------------
// fullwidth_indent_lexer: streaming lexer for full-width source text
// Each accepted word's tokens pass from the token registers into the single result
// register, one token a cycle while the receiver does not stall. A word yields up to
// MAX_INDENT + 1 tokens, and a new word is accepted only after the last token of
// the previous word has entered the result register.
// Reset: synchronous active low; line count returns to one, all else idle.
// ----------------------------------------------------------------------------
`default_nettype none
module fullwidth_indent_lexer
  import fwil_pkg::*;
#(
  parameter int MAX_INDENT = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  dp_cmd_t    cmd;
  dp_status_t status;

  fwil_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fwil_dp #(
    .MAX_INDENT (MAX_INDENT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .status   (status),
    .out_word (out_word)
  );

endmodule
`default_nettype wire

@@ test/fwil_checker.sv @@
// ----------------------------------------------------------------------------
// fwil_checker: token predictor and scoreboard for the full-width lexer
// Watches both channels, lexes every accepted input word itself and compares
// each accepted output word field by field with the oldest predicted token.
// ----------------------------------------------------------------------------
`default_nettype none
module fwil_checker
  import fwil_pkg::*;
#(
  parameter int MAX_INDENT = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_stall,
  input  wire in_word_t  in_word,
  input  wire logic      out_valid,
  input  wire logic      out_stall,
  input  wire out_word_t out_word,
  output int             fail_count,
  output int             tokens_due
);

  out_word_t   token_q[$];
  lex_mode_t   mode;
  logic [20:0] held;
  logic [31:0] ind_lvl;
  logic [31:0] run_len;
  logic [31:0] line_no;
  logic [31:0] pos;
  logic [31:0] tok_start;
  logic [15:0] tok_len;
  logic [63:0] acc;
  logic [20:0] kbuf [4];
  logic        ovf;
  logic        err_pend;
  int          n_step;

  function automatic logic [5:0] keyword_of();
    return kw_kind(tok_len, kbuf[0], kbuf[1], kbuf[2], kbuf[3]);
  endfunction

  task automatic push_tok(input logic [5:0] k, input logic [31:0] st, input logic [15:0] ln,
                          input logic [62:0] v, input logic o);
    out_word_t w;
    if (n_step >= MAX_INDENT + 2) return;
    w.token_kind = k;
    w.line = line_no;
    w.content_start = st;
    w.content_length = ln;
    w.number_value = v;
    w.number_overflow = o;
    w.lexer_error = err_pend;
    w.last = 1'b0;
    err_pend = 1'b0;
    token_q = {token_q, w};
    n_step++;
  endtask

  task automatic grow_len();
    if (tok_len != LEN_MAX) tok_len++;
  endtask

  task automatic sym_open(input logic [20:0] c, input logic [31:0] p);
    mode = M_SYM;
    tok_start = p;
    tok_len = 1;
    kbuf[0] = c;
  endtask

  task automatic sym_close();
    push_tok(keyword_of(), tok_start, tok_len, '0, 1'b0);
  endtask

  task automatic spaces_out();
    int d;
    logic [5:0] k;
    k = (run_len > ind_lvl) ? K_INDENT : K_DEDENT;
    d = (run_len > ind_lvl) ? run_len - ind_lvl : ind_lvl - run_len;
    for (int i = 0; i < d; i++) push_tok(k, '0, '0, '0, 1'b0);
    ind_lvl = run_len;
  endtask

  task automatic dedent_zero();
    for (int i = 0; i < ind_lvl; i++) push_tok(K_DEDENT, '0, '0, '0, 1'b0);
    ind_lvl = 0;
  endtask

  task automatic begin_char(input logic [20:0] c, input logic [31:0] p);
    mode = M_IDLE;
    if (is_cmp(c)) begin
      mode = M_CMP;
      held = c;
      tok_start = p;
    end else if (is_punct(c)) begin
      push_tok(punct_kind(c), p, 16'd1, '0, 1'b0);
    end else if (c == C_SHARP) begin
      mode = M_CMT;
    end else if (c == C_NL) begin
      line_no++;
      push_tok(K_NEWL, '0, '0, '0, 1'b0);
      if (ind_lvl > 0) mode = M_NLW;
    end else if (c == C_SPACE) begin
      mode = M_SPC;
      run_len = 1;
    end else if (is_digit(c)) begin
      mode = M_NUM;
      tok_start = p;
      tok_len = 1;
      acc = 64'(c - C_D0);
      ovf = 1'b0;
    end else if (c == C_LSQ) begin
      mode = M_STR;
      tok_start = p + 1;
      tok_len = 0;
    end else begin
      sym_open(c, p);
    end
  endtask

  task automatic sym_take(input logic [20:0] c, input logic [31:0] p);
    if (!is_symbolic(c)) begin
      if (tok_len < 4) kbuf[tok_len[1:0]] = c;
      grow_len();
    end else begin
      sym_close();
      begin_char(c, p);
    end
  endtask

  task automatic lex_char(input logic [20:0] c, input logic [31:0] p);
    logic [63:0] d;
    case (mode)
      M_CMP: begin
        if (is_cmp(c)) begin
          if (c == C_EQ) begin
            push_tok(held == C_EQ ? K_EQ : held == C_GT ? K_GEQ : held == C_LT ? K_LEQ : K_NEQ,
                     tok_start, 16'd2, '0, 1'b0);
            mode = M_IDLE;
          end else begin
            err_pend = 1'b1;
            if (held == C_NOT) sym_open(C_NOT, tok_start);
            else begin
              push_tok(punct_kind(held), tok_start, 16'd1, '0, 1'b0);
              mode = M_IDLE;
            end
          end
        end else if (held == C_NOT) begin
          sym_open(C_NOT, tok_start);
          sym_take(c, p);
        end else begin
          push_tok(punct_kind(held), tok_start, 16'd1, '0, 1'b0);
          begin_char(c, p);
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          d = 64'(c - C_D0);
          grow_len();
          if (!ovf) begin
            if (acc > ({1'b0, NUM_LIMIT} - d) / 10) begin
              acc = {1'b0, NUM_LIMIT};
              ovf = 1'b1;
            end else acc = acc * 10 + d;
          end
        end else begin
          push_tok(K_NUMBER, tok_start, tok_len, acc[62:0], ovf);
          begin_char(c, p);
        end
      end
      M_SYM: sym_take(c, p);
      M_STR: begin
        if (c == C_RSQ) begin
          push_tok(K_STRING, tok_start, tok_len, '0, 1'b0);
          mode = M_IDLE;
        end else begin
          grow_len();
          if (c == C_NL) line_no++;
        end
      end
      M_CMT: begin
        if (c == C_NL) begin
          line_no++;
          push_tok(K_NEWL, '0, '0, '0, 1'b0);
          mode = M_IDLE;
        end
      end
      M_SPC: begin
        if (c == C_SPACE) begin
          if (run_len < MAX_INDENT) run_len++;
        end else begin
          spaces_out();
          begin_char(c, p);
        end
      end
      M_NLW: begin
        if (c != C_SPACE && c != C_NL) dedent_zero();
        begin_char(c, p);
      end
      default: begin_char(c, p);
    endcase
  endtask

  task automatic lex_end();
    case (mode)
      M_CMP: push_tok(held == C_NOT ? K_SYMBOL : punct_kind(held), tok_start, 16'd1, '0, 1'b0);
      M_NUM: push_tok(K_NUMBER, tok_start, tok_len, acc[62:0], ovf);
      M_SYM: sym_close();
      M_SPC: spaces_out();
      M_NLW: dedent_zero();
      default: ;
    endcase
    err_pend = 1'b0;
    push_tok(K_END, '0, '0, '0, 1'b0);
    mode = M_IDLE;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      mode = M_IDLE;
      held = '0;
      ind_lvl = 0;
      run_len = 0;
      line_no = 1;
      pos = 0;
      tok_start = 0;
      tok_len = 0;
      acc = 0;
      for (int i = 0; i < 4; i++) kbuf[i] = '0;
      ovf = 1'b0;
      err_pend = 1'b0;
      fail_count = 0;
      token_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (token_q.size() == 0) begin
          $error("token_kind: expected none, actual %0d", out_word.token_kind);
          fail_count++;
        end else begin
          e = token_q.pop_front();
          check_field("token_kind", 64'(e.token_kind), 64'(out_word.token_kind));
          check_field("line", 64'(e.line), 64'(out_word.line));
          check_field("content_start", 64'(e.content_start), 64'(out_word.content_start));
          check_field("content_length", 64'(e.content_length), 64'(out_word.content_length));
          check_field("number_value", 64'(e.number_value), 64'(out_word.number_value));
          check_field("number_overflow", 64'(e.number_overflow),
                      64'(out_word.number_overflow));
          check_field("lexer_error", 64'(e.lexer_error), 64'(out_word.lexer_error));
          check_field("last", 64'(e.last), 64'(out_word.last));
        end
      end
      if (in_valid && !in_stall) begin
        n_step = 0;
        if (in_word.kind) lex_end();
        else begin
          lex_char(in_word.code_point, pos);
          pos = pos + 1;
        end
        if (n_step > 0) token_q[token_q.size() - 1].last = 1'b1;
      end
    end
    tokens_due = token_q.size();
  end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the full-width indent lexer
// Feeds directed and random full-width text in bursts against a randomly
// stalling receiver; the checker predicts and compares every token.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import fwil_pkg::*;

  localparam int MAX_INDENT = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  int        fail_count;
  int        tokens_due;
  int        burst_left = 0;
  int        stall_mode = 0;
  int        n_sent = 0;
  logic [20:0] pool [34];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fullwidth_indent_lexer #(.MAX_INDENT(MAX_INDENT)) u_top (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
  );

  fwil_checker #(.MAX_INDENT(MAX_INDENT)) u_check (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .fail_count(fail_count), .tokens_due(tokens_due)
  );

  always @(negedge clk) begin
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
  end

  task automatic send(input logic k, input logic [20:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    n_sent++;
    in_valid <= 1'b1;
    in_word <= '{kind: k, code_point: c};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic say(input logic [20:0] c);
    send(1'b0, c);
  endtask

  task automatic rand_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) say(pool[$urandom_range(0, 33)]);
    else if (r < 85) say(C_D0 + 21'($urandom_range(0, 9)));
    else if (r < 95) say(21'($urandom_range(21'h3040, 21'h30FF)));
    else say(21'($urandom));
  endtask

  task automatic say_kw(input int which);
    case (which)
      0: begin say(21'h95A2); say(21'h6570); end
      1: begin say(21'h8FD4); say(21'h3059); end
      2: begin say(21'h3082); say(21'h3057); end
      3: begin say(21'h4ED6); say(21'h3067); say(21'h3082); say(21'h3057); end
      4: begin say(21'h305D); say(21'h306E); say(21'h4ED6); end
      5: begin say(21'h5C0E); say(21'h5165); end
      6: begin say(21'h78BA); say(21'h8A8D); end
      default: begin say(21'h5916); say(21'h5074); end
    endcase
  endtask

  initial begin
    pool = '{C_NUL, C_NL, C_SPACE, C_COMMA, C_LSQ, C_RSQ, C_LBR, C_RBR, C_NAMI, C_DOT,
             C_NOT, C_SHARP, C_LPAR, C_RPAR, C_STAR, C_PLUS, C_MINUS, C_SLASH, C_D0,
             C_D9, C_COLON, C_LT, C_EQ, C_GT, C_SPACE, C_SPACE, C_NL, C_EQ, C_NOT,
             21'h1FFFFF, 21'h10FFFF, 21'h0041, 21'h95A2, 21'h3057};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int i = 0; i < 8; i++) say_kw(i);
    say(C_EQ); say(C_EQ); say(C_GT); say(C_EQ); say(C_LT); say(C_EQ);
    say(C_NOT); say(C_EQ); say(C_GT); say(C_LT); say(C_NOT); say(C_NOT);
    say(21'h0041); say(C_NL);
    for (int i = 0; i < 20; i++) say(C_SPACE);
    say(C_D9); say(C_NL); say(C_SHARP); say(C_SPACE); say(C_NL);
    for (int i = 0; i < 20; i++) say(C_D9);
    say(C_LSQ); say(C_NL); say(C_RSQ); say(C_NUL); say(21'h1FFFFF);
    send(1'b1, '0);
    for (int i = 0; i < 24; i++) say(pool[i]);
    send(1'b1, 21'h1FFFFF);
    while (n_sent < 470) begin
      case ($urandom_range(0, 9))
        0: begin say(C_NL); repeat ($urandom_range(0, 18)) say(C_SPACE); end
        1: say_kw($urandom_range(0, 7));
        2: begin say(pool[$urandom_range(21, 23)]); say(pool[$urandom_range(21, 28)]); end
        3: repeat ($urandom_range(1, 21)) say(C_D0 + 21'($urandom_range(0, 9)));
        4: if ($urandom_range(0, 3) == 0) send(1'b1, 21'($urandom));
           else rand_char();
        default: rand_char();
      endcase
    end
    send(1'b1, '0);
    in_valid <= 1'b0;
    while (tokens_due != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && tokens_due == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
